>>> rtl/core/infix_to_postfix_converter_core_macros.svh
// assertion macros for the converter rtl
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_MACROS_SVH

// condition must hold at every edge out of reset
`define I2P_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define I2P_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/i2p_pkg.sv
// package: constants, types and helper functions of the infix to postfix converter
`timescale 1ns / 1ps

package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_ADD    = 8'h2B;
  localparam logic [7:0] CH_SUB    = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNMATCHED = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLOSE,
    ST_OPPOP,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] sym;
  } stk_cmd_t;

  typedef struct packed {
    logic [7:0]       top;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] paren;
    logic             top_ok;
  } stk_stat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] sym;
    logic       sym_valid;
    logic       last;
    err_t       err;
  } emit_t;

  function automatic logic is_op(input logic [7:0] ch);
    return (ch == CH_MUL) || (ch == CH_DIV) || (ch == CH_ADD) || (ch == CH_SUB);
  endfunction

  // '(' never reaches the compare, so only operator ranks matter here
  function automatic logic [1:0] rank_of(input logic [7:0] ch);
    logic [1:0] r;
    r = 2'd0;
    if ((ch == CH_MUL) || (ch == CH_DIV)) r = 2'd2;
    else if ((ch == CH_ADD) || (ch == CH_SUB)) r = 2'd1;
    return r;
  endfunction

endpackage

>>> rtl/core/infix_to_postfix_converter_core.sv
// top level: infix to postfix converter with operator stack and output register
`timescale 1ns / 1ps

// Shunting-yard converter. Characters of an infix expression enter one beat
// at a time on the item channel, the final one flagged by end_of_expression,
// and the postfix form leaves on the result channel. One character is worked
// on at a time: a beat is taken, decoded in the next cycle, and the block
// takes no new beat until that character is finished. Each operator popped
// from the stack is emitted, and the next stack entry is then read back from
// the stack memory into the top register before the stack is used again; a
// ')' or an operator that pops then drops the '(' or pushes the operator. An
// end flag starts a flush that pops and emits every entry left on the stack.
// Result beats wait in one output register and a stall there holds the
// sequencer. Errors (an unmatched ')' or a push onto a full stack of 32
// entries) give one error beat and leave the stack as it was. No clearing
// pass is needed after reset.
module infix_to_postfix_converter_core (
  input  logic       clk,
  input  logic       rst,
  // item channel
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [7:0] symbol,
  input  logic       end_of_expression,
  // result channel
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_symbol,
  output logic       symbol_valid,
  output logic       last,
  output logic [1:0] error
);

  i2p_pkg::stk_cmd_t  cmd;
  i2p_pkg::stk_stat_t stat;
  i2p_pkg::emit_t     emit;
  logic               idle;
  logic               item_take;
  logic               can_emit;

  // busy for the whole life of a character
  assign item_stall = !idle;
  assign item_take  = item_valid && idle;

  // the output register may be refilled in the cycle its beat is taken
  assign can_emit = !result_valid || !result_stall;

  i2p_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .item_take         (item_take),
    .symbol            (symbol),
    .end_of_expression (end_of_expression),
    .can_emit          (can_emit),
    .stat              (stat),
    .idle              (idle),
    .cmd               (cmd),
    .emit              (emit)
  );

  i2p_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  // result register: valid under reset, payload only loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit.valid) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_symbol   <= emit.sym;
      symbol_valid <= emit.sym_valid;
      last         <= emit.last;
      error        <= emit.err;
    end
  end

endmodule

>>> rtl/core/i2p_stack.sv
// operator stack: memory for lower entries, cached top register and counters
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_core_macros.svh"

module i2p_stack (
  input  logic                clk,
  input  logic                rst,
  input  i2p_pkg::stk_cmd_t   cmd,
  output i2p_pkg::stk_stat_t  stat
);

  logic [7:0]                  mem [i2p_pkg::STACK_DEPTH];
  logic [7:0]                  rd_data;
  logic [i2p_pkg::ADDR_W-1:0]  rd_addr;
  logic [i2p_pkg::ADDR_W-1:0]  wr_addr;
  logic [7:0]                  top;
  logic [i2p_pkg::CNT_W-1:0]   count;
  logic [i2p_pkg::CNT_W-1:0]   paren;
  logic                        refill;

  // entry count-1 lives in top, entries below it in the memory
  assign wr_addr = i2p_pkg::ADDR_W'(count - i2p_pkg::CNT_W'(1));
  assign rd_addr = i2p_pkg::ADDR_W'(count - i2p_pkg::CNT_W'(2));

  always_ff @(posedge clk) begin
    if (cmd.push && (count != '0)) begin
      mem[wr_addr] <= top;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top <= cmd.sym;
    end else if (refill) begin
      top <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      paren  <= '0;
      refill <= 1'b0;
    end else begin
      refill <= cmd.pop;
      if (cmd.push) begin
        count <= count + i2p_pkg::CNT_W'(1);
        if (cmd.sym == i2p_pkg::CH_LPAREN) paren <= paren + i2p_pkg::CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - i2p_pkg::CNT_W'(1);
        if (top == i2p_pkg::CH_LPAREN) paren <= paren - i2p_pkg::CNT_W'(1);
      end
    end
  end

  assign stat.top    = top;
  assign stat.count  = count;
  assign stat.paren  = paren;
  assign stat.top_ok = !refill;

  `I2P_ASSERT_ALWAYS(a_paren_le_count, paren <= count, "open count exceeds stack fill")
  `I2P_ASSERT_ALWAYS(a_no_pop_empty, !(cmd.pop && (count == '0)), "pop on empty stack")
  `I2P_ASSERT_ALWAYS(a_no_push_full, !(cmd.push && (count == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH))), "push on full stack")
  `I2P_ASSERT_NEXT(a_no_op_during_refill, cmd.pop, !cmd.push && !cmd.pop, "stack command during top refill")

endmodule

>>> rtl/core/i2p_ctrl.sv
// sequencer: decodes characters, one stack action a cycle unless stalled
`timescale 1ns / 1ps

module i2p_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_take,
  input  logic [7:0]          symbol,
  input  logic                end_of_expression,
  input  logic                can_emit,
  input  i2p_pkg::stk_stat_t  stat,
  output logic                idle,
  output i2p_pkg::stk_cmd_t   cmd,
  output i2p_pkg::emit_t      emit
);

  i2p_pkg::state_t state, state_next;
  logic [7:0]      sym;
  logic            end_flag;
  logic            emitted, emitted_next;
  logic            full;
  logic            top_pops;
  logic            nonempty;

  assign full     = (stat.count == i2p_pkg::CNT_W'(i2p_pkg::STACK_DEPTH));
  assign nonempty = (stat.count != '0);
  // the one rank compare, shared by decode and the pop loop
  assign top_pops = (stat.top != i2p_pkg::CH_LPAREN) &&
                    (i2p_pkg::rank_of(sym) <= i2p_pkg::rank_of(stat.top));
  assign idle     = (state == i2p_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= i2p_pkg::ST_IDLE;
      emitted <= 1'b0;
    end else begin
      state   <= state_next;
      emitted <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      sym      <= symbol;
      end_flag <= end_of_expression;
    end
  end

  always_comb begin
    state_next     = state;
    emitted_next   = emitted;
    cmd            = '0;
    emit           = '0;
    emit.err       = i2p_pkg::ERR_NONE;
    unique case (state)
      i2p_pkg::ST_IDLE: begin
        if (item_take) begin
          state_next   = i2p_pkg::ST_DECODE;
          emitted_next = 1'b0;
        end
      end
      i2p_pkg::ST_DECODE: begin
        if (stat.top_ok) begin
          priority if (sym == i2p_pkg::CH_SPACE) begin
            state_next = end_flag ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_IDLE;
          end else if (sym == i2p_pkg::CH_LPAREN) begin
            if (full) begin
              if (can_emit) begin
                emit.valid = 1'b1;
                emit.err   = i2p_pkg::ERR_OVERFLOW;
                state_next = i2p_pkg::ST_IDLE;
              end
            end else begin
              cmd.push   = 1'b1;
              cmd.sym    = sym;
              state_next = end_flag ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_IDLE;
            end
          end else if (sym == i2p_pkg::CH_RPAREN) begin
            if (stat.paren == '0) begin
              if (can_emit) begin
                emit.valid = 1'b1;
                emit.err   = i2p_pkg::ERR_UNMATCHED;
                state_next = i2p_pkg::ST_IDLE;
              end
            end else begin
              state_next = i2p_pkg::ST_CLOSE;
            end
          end else if (i2p_pkg::is_op(sym)) begin
            if (nonempty && top_pops) begin
              state_next = i2p_pkg::ST_OPPOP;
            end else if (full) begin
              if (can_emit) begin
                emit.valid = 1'b1;
                emit.err   = i2p_pkg::ERR_OVERFLOW;
                state_next = i2p_pkg::ST_IDLE;
              end
            end else begin
              cmd.push   = 1'b1;
              cmd.sym    = sym;
              state_next = end_flag ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_IDLE;
            end
          end else begin
            if (can_emit) begin
              emit.valid     = 1'b1;
              emit.sym       = sym;
              emit.sym_valid = 1'b1;
              emit.last      = end_flag && !nonempty;
              emitted_next   = 1'b1;
              state_next     = end_flag ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_IDLE;
            end
          end
        end
      end
      i2p_pkg::ST_CLOSE: begin
        if (stat.top_ok) begin
          if (stat.top == i2p_pkg::CH_LPAREN) begin
            cmd.pop    = 1'b1;
            state_next = end_flag ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_IDLE;
          end else if (can_emit) begin
            // last beat only if just the matching open bracket remains below this one
            emit.valid     = 1'b1;
            emit.sym       = stat.top;
            emit.sym_valid = 1'b1;
            emit.last      = end_flag && (stat.count == i2p_pkg::CNT_W'(2));
            emitted_next   = 1'b1;
            cmd.pop        = 1'b1;
          end
        end
      end
      i2p_pkg::ST_OPPOP: begin
        if (stat.top_ok) begin
          if (nonempty && top_pops) begin
            if (can_emit) begin
              emit.valid     = 1'b1;
              emit.sym       = stat.top;
              emit.sym_valid = 1'b1;
              emitted_next   = 1'b1;
              cmd.pop        = 1'b1;
            end
          end else begin
            cmd.push   = 1'b1;
            cmd.sym    = sym;
            state_next = end_flag ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_IDLE;
          end
        end
      end
      i2p_pkg::ST_FLUSH: begin
        if (stat.top_ok) begin
          if (nonempty) begin
            if (can_emit) begin
              emit.valid     = 1'b1;
              emit.sym       = stat.top;
              emit.sym_valid = 1'b1;
              emit.last      = (stat.count == i2p_pkg::CNT_W'(1));
              emitted_next   = 1'b1;
              cmd.pop        = 1'b1;
            end
          end else if (!emitted) begin
            if (can_emit) begin
              emit.valid   = 1'b1;
              emit.last    = 1'b1;
              emitted_next = 1'b1;
              state_next   = i2p_pkg::ST_IDLE;
            end
          end else begin
            state_next = i2p_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = i2p_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
